// ----- sv/kts_pkg.sv -----
package kts_pkg;

    localparam int MAX_KEYS_DEF = 16;
    localparam int NCOMP        = 9;
    localparam int COMP_W       = 32;
    localparam int ROW_W        = NCOMP * COMP_W;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] ST_SAMPLED = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_STORED  = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] time_point;
        logic               wrap_mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] scl_x;
        logic signed [31:0] scl_y;
        logic signed [31:0] scl_z;
    } t_kts_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_rot_x;
        logic signed [31:0] out_rot_y;
        logic signed [31:0] out_rot_z;
        logic signed [31:0] out_scl_x;
        logic signed [31:0] out_scl_y;
        logic signed [31:0] out_scl_z;
    } t_kts_out;

    // component j sits at bits [32*j +: 32], position x lowest
    function automatic t_row item_row(input t_kts_in it);
        item_row = {it.scl_z, it.scl_y, it.scl_x, it.rot_z, it.rot_y, it.rot_x,
                    it.pos_z, it.pos_y, it.pos_x};
    endfunction

    function automatic t_kts_out make_out(input logic [1:0] st, input t_row row);
        t_kts_out o;
        o.status    = st;
        o.out_pos_x = row[0*COMP_W +: COMP_W];
        o.out_pos_y = row[1*COMP_W +: COMP_W];
        o.out_pos_z = row[2*COMP_W +: COMP_W];
        o.out_rot_x = row[3*COMP_W +: COMP_W];
        o.out_rot_y = row[4*COMP_W +: COMP_W];
        o.out_rot_z = row[5*COMP_W +: COMP_W];
        o.out_scl_x = row[6*COMP_W +: COMP_W];
        o.out_scl_y = row[7*COMP_W +: COMP_W];
        o.out_scl_z = row[8*COMP_W +: COMP_W];
        return o;
    endfunction

endpackage

// ----- sv/kts_ram.sv -----
module kts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wen,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sv/kts_front.sv -----
module kts_front
    import kts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_kts_in i_data,
    output logic    o_valid,
    input  logic    i_pop,
    output t_kts_in o_data,
    output logic    o_is_sample
);

    // two-entry transaction queue
    t_kts_in    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_valid     = (r_cnt != 2'd0);
    assign o_data      = r_q[r_rp];
    assign o_is_sample = (r_q[r_rp].operation == OP_SAMPLE);
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ----- sv/kts_engine.sv -----
module kts_engine
    import kts_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_kts_in  i_item,
    input  logic     i_is_sample,
    output logic     o_pop,
    output logic     o_valid,
    input  logic     i_ready,
    output t_kts_out o_data
);

    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_INS_RD   = 5'd1;
    localparam logic [4:0] S_INS_CHK  = 5'd2;
    localparam logic [4:0] S_INS_PUT  = 5'd3;
    localparam logic [4:0] S_SMP_RDL  = 5'd4;
    localparam logic [4:0] S_SMP_GETL = 5'd5;
    localparam logic [4:0] S_SMP_RD0  = 5'd6;
    localparam logic [4:0] S_SMP_GET0 = 5'd7;
    localparam logic [4:0] S_MOD      = 5'd8;
    localparam logic [4:0] S_CLAMP    = 5'd9;
    localparam logic [4:0] S_OUT_RD   = 5'd10;
    localparam logic [4:0] S_OUT_GET  = 5'd11;
    localparam logic [4:0] S_SCN_RD   = 5'd12;
    localparam logic [4:0] S_SCN_CHK  = 5'd13;
    localparam logic [4:0] S_FDIV     = 5'd14;
    localparam logic [4:0] S_MUL      = 5'd15;
    localparam logic [4:0] S_ADD      = 5'd16;
    localparam logic [4:0] S_EMIT     = 5'd17;

    logic [4:0]         r_state;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_i;
    logic [IW-1:0]      r_wp;
    t_kts_in            r_item;
    logic signed [31:0] r_t;
    logic signed [31:0] r_t0;
    logic signed [31:0] r_dur;
    logic signed [31:0] r_ta;
    logic               r_neg;
    logic [31:0]        r_num;
    logic [32:0]        r_rem;
    logic [33:0]        r_frem;
    logic [32:0]        r_den;
    logic [16:0]        r_q;
    logic [5:0]         r_k;
    logic [3:0]         r_j;
    logic signed [50:0] r_prod;
    t_row               r_ca;
    t_row               r_cb;
    t_row               r_acc;
    logic               r_ovld;
    t_kts_out           r_out;

    logic               w_wen;
    logic [IW-1:0]      w_waddr;
    logic [31:0]        w_wtime;
    t_row               w_wrow;
    logic signed [31:0] w_rtime;
    t_row               w_rrow;
    logic [32:0]        w_mtrial;
    logic [32:0]        w_mrem;
    logic [33:0]        w_ftrial;
    logic               w_fge;
    logic [33:0]        w_frem;
    logic [32:0]        w_d;
    logic [32:0]        w_dn;
    logic signed [31:0] w_ca_j;
    logic signed [31:0] w_cb_j;
    logic signed [32:0] w_diff;
    logic               w_start;

    kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
        .i_clk  (i_clk),
        .i_wen  (w_wen),
        .i_waddr(w_waddr),
        .i_wdata(w_wtime),
        .i_raddr(r_i[IW-1:0]),
        .o_rdata(w_rtime)
    );

    kts_ram #(.WIDTH(ROW_W), .DEPTH(MAX_KEYS)) u_rows (
        .i_clk  (i_clk),
        .i_wen  (w_wen),
        .i_waddr(w_waddr),
        .i_wdata(w_wrow),
        .i_raddr(r_i[IW-1:0]),
        .o_rdata(w_rrow)
    );

    assign w_start = (r_state == S_IDLE) && i_valid && !r_ovld;
    assign o_pop   = w_start;
    assign o_valid = r_ovld;
    assign o_data  = r_out;

    // table writes: shift one key up, or drop the new key in place
    always_comb begin
        w_wen   = 1'b0;
        w_waddr = IW'(r_i + CW'(1));
        w_wtime = w_rtime;
        w_wrow  = w_rrow;
        if (r_state == S_INS_PUT) begin
            w_wen   = 1'b1;
            w_waddr = r_wp;
            w_wtime = r_t;
            w_wrow  = item_row(r_item);
        end else if (r_state == S_INS_CHK && w_rtime > r_t) begin
            w_wen = 1'b1;
        end
    end

    always_comb begin
        w_mtrial = {r_rem[31:0], r_num[31]};
        w_mrem   = (w_mtrial >= {1'b0, r_dur}) ? w_mtrial - {1'b0, r_dur} : w_mtrial;
        w_ftrial = (r_k == 6'd0) ? r_frem : {r_frem[32:0], 1'b0};
        w_fge    = (w_ftrial >= {1'b0, r_den});
        w_frem   = w_fge ? w_ftrial - {1'b0, r_den} : w_ftrial;
        w_d      = {r_t[31], r_t} - {r_ta[31], r_ta};
        w_dn     = {w_rtime[31], w_rtime} - {r_ta[31], r_ta};
        w_ca_j   = r_ca[32*r_j +: 32];
        w_cb_j   = r_cb[32*r_j +: 32];
        w_diff   = {w_cb_j[31], w_cb_j} - {w_ca_j[31], w_ca_j};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_item <= i_item;
                        r_t    <= i_item.time_point;
                        if (!i_is_sample) begin
                            if (r_cnt >= CW'(MAX_KEYS)) begin
                                r_out  <= make_out(ST_DROPPED, '0);
                                r_ovld <= 1'b1;
                            end else if (r_cnt == '0) begin
                                r_wp    <= '0;
                                r_state <= S_INS_PUT;
                            end else begin
                                r_i     <= r_cnt - CW'(1);
                                r_state <= S_INS_RD;
                            end
                        end else if (r_cnt == '0) begin
                            r_out <= make_out(ST_EMPTY,
                                              {ONE_Q16, ONE_Q16, ONE_Q16, 192'd0});
                            r_ovld <= 1'b1;
                        end else begin
                            r_i     <= r_cnt - CW'(1);
                            r_state <= S_SMP_RDL;
                        end
                    end
                end
                S_INS_RD: r_state <= S_INS_CHK;
                S_INS_CHK: begin
                    if (w_rtime > r_t) begin
                        if (r_i == '0) begin
                            r_wp    <= '0;
                            r_state <= S_INS_PUT;
                        end else begin
                            r_i     <= r_i - CW'(1);
                            r_state <= S_INS_RD;
                        end
                    end else begin
                        r_wp    <= IW'(r_i + CW'(1));
                        r_state <= S_INS_PUT;
                    end
                end
                S_INS_PUT: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_out   <= make_out(ST_STORED, '0);
                    r_ovld  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SMP_RDL: r_state <= S_SMP_GETL;
                S_SMP_GETL: begin
                    r_dur   <= w_rtime;
                    r_i     <= '0;
                    r_state <= S_SMP_RD0;
                end
                S_SMP_RD0: r_state <= S_SMP_GET0;
                S_SMP_GET0: begin
                    r_t0 <= w_rtime;
                    if (r_item.wrap_mode && r_dur > 32'sd0) begin
                        r_neg   <= r_t[31];
                        r_num   <= r_t[31] ? 32'(-r_t) : r_t;
                        r_rem   <= '0;
                        r_k     <= '0;
                        r_state <= S_MOD;
                    end else begin
                        r_state <= S_CLAMP;
                    end
                end
                S_MOD: begin
                    r_rem <= w_mrem;
                    r_num <= {r_num[30:0], 1'b0};
                    r_k   <= r_k + 6'd1;
                    if (r_k == 6'd31) begin
                        r_t     <= r_neg ? 32'(-w_mrem[31:0]) : w_mrem[31:0];
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    if (r_t <= r_t0) begin
                        r_i     <= '0;
                        r_state <= S_OUT_RD;
                    end else if (r_t >= r_dur) begin
                        r_i     <= r_cnt - CW'(1);
                        r_state <= S_OUT_RD;
                    end else begin
                        r_i     <= CW'(1);
                        r_ta    <= r_t0;
                        r_state <= S_SCN_RD;
                    end
                end
                S_OUT_RD: r_state <= S_OUT_GET;
                S_OUT_GET: begin
                    r_out   <= make_out(ST_SAMPLED, w_rrow);
                    r_ovld  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SCN_RD: r_state <= S_SCN_CHK;
                S_SCN_CHK: begin
                    if (r_t >= r_ta && r_t <= w_rtime && w_rtime > r_ta) begin
                        r_cb    <= w_rrow;
                        r_frem  <= {1'b0, w_d};
                        r_den   <= w_dn;
                        r_q     <= '0;
                        r_k     <= '0;
                        r_i     <= r_i - CW'(1);
                        r_state <= S_FDIV;
                    end else if (r_i == r_cnt - CW'(1)) begin
                        r_state <= S_OUT_RD;
                    end else begin
                        r_ta    <= w_rtime;
                        r_i     <= r_i + CW'(1);
                        r_state <= S_SCN_RD;
                    end
                end
                S_FDIV: begin
                    r_frem <= w_frem;
                    r_q    <= {r_q[15:0], w_fge};
                    r_k    <= r_k + 6'd1;
                    if (r_k == 6'd1) begin
                        r_ca <= w_rrow;
                    end
                    if (r_k == 6'd16) begin
                        r_j     <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_diff * $signed({1'b0, r_q});
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc[32*r_j +: 32] <= w_ca_j + r_prod[47:16];
                    if (r_j == 4'(NCOMP - 1)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_j     <= r_j + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_EMIT: begin
                    r_out   <= make_out(ST_SAMPLED, r_acc);
                    r_ovld  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/keyframe_transform_sampler_core.sv -----
// Keyframe table with linear sampling. Each input transaction either inserts a
// keyframe (time plus position, rotation and scale xyz, all signed Q16.16) into a
// time-sorted table of MAX_KEYS entries, placed after any keys of equal time, or
// samples the table at a time, optionally wrapped modulo the last key time when
// that is positive. Every transaction yields exactly one result: status 2 on a
// stored key, 3 when the table is full and the key is dropped, 1 for a sample of
// an empty table (zero position and rotation, unit scale) and 0 for a sample,
// clamped to the first or last key or lerped between the bracketing pair.
// A two-entry queue takes transactions while the engine works; a transaction is
// registered in the queue before the engine can take it. The engine handles one
// at a time with one read port per table memory. An insert reads and compares the
// stored keys from the last one down, shifting each key of later time up, then
// writes the new key; a full-table insert or an empty-table sample is answered
// straight from the idle state. A sample reads the last and first keys, wraps the
// time by a bit-serial remainder when wrapping and runs the clamp test; it then
// reads out a clamped key, or else scans key pairs, divides bit-serially for the
// factor, does the nine multiply-add steps and registers the result.
// The result register holds until taken; the engine starts the next transaction
// only once it is empty. The table needs no clearing after reset.
module keyframe_transform_sampler_core
    import kts_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_kts_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_kts_out o_out_data
);

    t_kts_in w_item;
    logic    w_item_valid;
    logic    w_is_sample;
    logic    w_pop;

    // front: queue and classify incoming transactions
    kts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_data     (i_in_data),
        .o_valid    (w_item_valid),
        .i_pop      (w_pop),
        .o_data     (w_item),
        .o_is_sample(w_is_sample)
    );

    // back: table maintenance, search, division and lerp
    kts_engine #(.MAX_KEYS(MAX_KEYS)) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_item_valid),
        .i_item     (w_item),
        .i_is_sample(w_is_sample),
        .o_pop      (w_pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

endmodule
